// File: sv/mbc_pkg.sv
// shared types and constants of the bpsk combiner and slicer
`timescale 1ns / 1ps
`default_nettype none

package mbc_pkg;

    localparam int RX_ANTENNAS = 8;

    localparam int ANT_W      = 3;
    localparam int VALUE_W    = 16;
    localparam int GAIN_W     = 19;
    localparam int PROD_W     = GAIN_W + VALUE_W;
    localparam int ACC_W      = 38;
    localparam int COUNT_W    = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW   = $clog2(QUEUE_DEPTH);

    // the antenna field reaches at most 2**ANT_W entries
    localparam int GAIN_DEPTH = (RX_ANTENNAS < (1 << ANT_W)) ? RX_ANTENNAS : (1 << ANT_W);
    localparam int GIDX_W     = (GAIN_DEPTH > 1) ? $clog2(GAIN_DEPTH) : 1;

    typedef enum logic [1:0] {
        FUNC_CLEAR   = 2'd0,
        FUNC_COEF    = 2'd1,
        FUNC_SAMPLE  = 2'd2,
        FUNC_CLR_ERR = 2'd3
    } t_func;

    typedef struct packed {
        t_func                      func;
        logic                       ant_ok;
        logic [GIDX_W-1:0]          idx;
        logic signed [VALUE_W-1:0]  value_re;
        logic signed [VALUE_W-1:0]  value_im;
        logic                       sent_bit;
        logic                       last;
    } t_op;

endpackage

`default_nettype wire

// File: sv/mbc_front.sv
// front end: takes input beats and classifies them into queue entries
`timescale 1ns / 1ps
`default_nettype none

module mbc_front (
    input  wire logic                               i_valid,
    input  wire logic [1:0]                         i_func,
    input  wire logic [mbc_pkg::ANT_W-1:0]          i_antenna,
    input  wire logic signed [mbc_pkg::VALUE_W-1:0] i_value_re,
    input  wire logic signed [mbc_pkg::VALUE_W-1:0] i_value_im,
    input  wire logic                               i_sent_bit,
    input  wire logic                               i_last_antenna,
    input  wire logic                               i_queue_full,
    output mbc_pkg::t_op                            o_op,
    output logic                                    o_push,
    output logic                                    o_ready
);

    mbc_pkg::t_func w_func;

    // every 2-bit code is a defined func
    assign w_func = mbc_pkg::t_func'(i_func);

    always_comb begin
        o_op.func     = w_func;
        // indices past the last receive antenna take no part
        o_op.ant_ok   = (int'(i_antenna) < mbc_pkg::RX_ANTENNAS);
        o_op.idx      = i_antenna[mbc_pkg::GIDX_W-1:0];
        o_op.value_re = i_value_re;
        o_op.value_im = i_value_im;
        o_op.sent_bit = i_sent_bit;
        o_op.last     = i_last_antenna;
    end

    assign o_ready = !i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

endmodule

`default_nettype wire

// File: sv/mbc_queue.sv
// small fifo between front and back ends
`timescale 1ns / 1ps
`default_nettype none

module mbc_queue (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire mbc_pkg::t_op i_op,
    input  wire logic   i_pop,
    output mbc_pkg::t_op o_head,
    output logic        o_empty,
    output logic        o_full
);

    mbc_pkg::t_op                  r_mem [mbc_pkg::QUEUE_DEPTH];
    logic [mbc_pkg::QUEUE_AW-1:0]  r_wr_ptr;
    logic [mbc_pkg::QUEUE_AW-1:0]  r_rd_ptr;
    logic [mbc_pkg::QUEUE_AW:0]    r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (mbc_pkg::QUEUE_AW+1)'(mbc_pkg::QUEUE_DEPTH));
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/mbc_back.sv
// back end: gain table and products, then accumulate, slice and count errors
`timescale 1ns / 1ps
`default_nettype none

module mbc_back (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire mbc_pkg::t_op                       i_head,
    input  wire logic                               i_empty,
    output logic                                    o_pop,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic                                    o_decoded_bit,
    output logic                                    o_bit_error,
    output logic [mbc_pkg::COUNT_W-1:0]             o_error_total,
    output logic signed [mbc_pkg::ACC_W-1:0]        o_combined_metric
);

    localparam int SUM_W = mbc_pkg::ACC_W + 1;

    // gain table
    logic signed [mbc_pkg::GAIN_W-1:0] r_gain_re [mbc_pkg::GAIN_DEPTH];
    logic signed [mbc_pkg::GAIN_W-1:0] r_gain_im [mbc_pkg::GAIN_DEPTH];

    // product stage
    logic                              r_s1_valid;
    mbc_pkg::t_func                    r_s1_func;
    logic                              r_s1_sent;
    logic                              r_s1_last;
    logic signed [mbc_pkg::PROD_W-1:0] r_s1_prod_re;
    logic signed [mbc_pkg::PROD_W-1:0] r_s1_prod_im;

    // accumulate stage state
    logic signed [mbc_pkg::ACC_W-1:0]  r_acc;
    logic [mbc_pkg::COUNT_W-1:0]       r_err_cnt;

    logic                              w_advance;
    logic signed [mbc_pkg::GAIN_W-1:0] w_g_re;
    logic signed [mbc_pkg::GAIN_W-1:0] w_g_im;
    logic signed [mbc_pkg::PROD_W-1:0] w_prod_re;
    logic signed [mbc_pkg::PROD_W-1:0] w_prod_im;
    logic signed [SUM_W-1:0]           w_sum;
    logic signed [mbc_pkg::ACC_W-1:0]  w_acc_sat;
    logic                              w_bit;
    logic                              w_err;
    logic [mbc_pkg::COUNT_W-1:0]       w_cnt_next;

    assign w_advance = !o_valid || i_ready;
    assign o_pop     = w_advance && !i_empty;

    assign w_g_re    = r_gain_re[i_head.idx];
    assign w_g_im    = r_gain_im[i_head.idx];
    assign w_prod_re = mbc_pkg::PROD_W'(w_g_re) * mbc_pkg::PROD_W'(i_head.value_re);
    assign w_prod_im = mbc_pkg::PROD_W'(w_g_im) * mbc_pkg::PROD_W'(i_head.value_im);

    always_comb begin
        w_sum = SUM_W'(r_acc) + SUM_W'(r_s1_prod_re) + SUM_W'(r_s1_prod_im);
        if (w_sum[SUM_W-1] != w_sum[SUM_W-2]) begin
            // saturate toward the sign of the true sum
            w_acc_sat = w_sum[SUM_W-1] ? {1'b1, {(mbc_pkg::ACC_W-1){1'b0}}}
                                       : {1'b0, {(mbc_pkg::ACC_W-1){1'b1}}};
        end else begin
            w_acc_sat = w_sum[mbc_pkg::ACC_W-1:0];
        end
        w_bit = !w_acc_sat[mbc_pkg::ACC_W-1] && (w_acc_sat != '0);
        w_err = w_bit ^ r_s1_sent;
        w_cnt_next = (w_err && (r_err_cnt != '1)) ? r_err_cnt + 1'b1 : r_err_cnt;
    end

    // gain table updates and product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mbc_pkg::GAIN_DEPTH; i++) begin
                r_gain_re[i] <= '0;
                r_gain_im[i] <= '0;
            end
            r_s1_valid <= 1'b0;
        end else if (w_advance) begin
            r_s1_valid <= !i_empty;
            if (!i_empty) begin
                case (i_head.func)
                    mbc_pkg::FUNC_CLEAR: begin
                        for (int i = 0; i < mbc_pkg::GAIN_DEPTH; i++) begin
                            r_gain_re[i] <= '0;
                            r_gain_im[i] <= '0;
                        end
                    end
                    mbc_pkg::FUNC_COEF: begin
                        if (i_head.ant_ok) begin
                            r_gain_re[i_head.idx] <= w_g_re + mbc_pkg::GAIN_W'(i_head.value_re);
                            r_gain_im[i_head.idx] <= w_g_im + mbc_pkg::GAIN_W'(i_head.value_im);
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && !i_empty) begin
            r_s1_func <= i_head.func;
            r_s1_sent <= i_head.sent_bit;
            r_s1_last <= i_head.last;
            if (i_head.func == mbc_pkg::FUNC_SAMPLE && i_head.ant_ok) begin
                r_s1_prod_re <= w_prod_re;
                r_s1_prod_im <= w_prod_im;
            end else begin
                r_s1_prod_re <= '0;
                r_s1_prod_im <= '0;
            end
        end
    end

    // accumulate, slice and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_err_cnt <= '0;
            o_valid   <= 1'b0;
        end else if (w_advance) begin
            o_valid <= r_s1_valid && (r_s1_func == mbc_pkg::FUNC_SAMPLE) && r_s1_last;
            if (r_s1_valid) begin
                case (r_s1_func)
                    mbc_pkg::FUNC_CLEAR:   r_acc <= '0;
                    mbc_pkg::FUNC_CLR_ERR: r_err_cnt <= '0;
                    mbc_pkg::FUNC_SAMPLE: begin
                        if (r_s1_last) begin
                            r_acc     <= '0;
                            r_err_cnt <= w_cnt_next;
                        end else begin
                            r_acc <= w_acc_sat;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_s1_valid && r_s1_func == mbc_pkg::FUNC_SAMPLE && r_s1_last) begin
            o_decoded_bit     <= w_bit;
            o_bit_error       <= w_err;
            o_error_total     <= w_cnt_next;
            o_combined_metric <= w_acc_sat;
        end
    end

endmodule

`default_nettype wire

// File: sv/mrc_bpsk_combiner_slicer.sv
// top level of the maximal ratio combiner with bpsk slicer
// Accepts one beat per cycle and sustains one per cycle while results are taken.
// Beats are classified by func in the front end and enter a four-entry queue;
// the back end pops one entry per cycle while not stalled into a product stage
// (gain table lookup and two 19x16 multiplies) and then an accumulate stage
// (saturating 38-bit add, sign slice, saturating error count) that loads the
// result register. The back end stalls only while a result waits in the output
// register; the queue then absorbs up to four further beats before o_in_ready
// falls. Gains, the accumulator and the error count are cleared by reset; func 0
// clears gains and the accumulator, func 3 clears the error count, and every
// symbol-ending sample returns the accumulator to zero while keeping the gains.
`timescale 1ns / 1ps
`default_nettype none

module mrc_bpsk_combiner_slicer (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // input channel
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [1:0]                         i_func,
    input  wire logic [mbc_pkg::ANT_W-1:0]          i_antenna,
    input  wire logic signed [mbc_pkg::VALUE_W-1:0] i_value_re,
    input  wire logic signed [mbc_pkg::VALUE_W-1:0] i_value_im,
    input  wire logic                               i_sent_bit,
    input  wire logic                               i_last_antenna,
    // result channel
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic                                    o_decoded_bit,
    output logic                                    o_bit_error,
    output logic [mbc_pkg::COUNT_W-1:0]             o_error_total,
    output logic signed [mbc_pkg::ACC_W-1:0]        o_combined_metric
);

    mbc_pkg::t_op w_op;
    mbc_pkg::t_op w_head;
    logic         w_push;
    logic         w_pop;
    logic         w_empty;
    logic         w_full;

    // classify the incoming beat
    mbc_front u_front (
        .i_valid        (i_in_valid),
        .i_func         (i_func),
        .i_antenna      (i_antenna),
        .i_value_re     (i_value_re),
        .i_value_im     (i_value_im),
        .i_sent_bit     (i_sent_bit),
        .i_last_antenna (i_last_antenna),
        .i_queue_full   (w_full),
        .o_op           (w_op),
        .o_push         (w_push),
        .o_ready        (o_in_ready)
    );

    // decouples intake from a stalled result
    mbc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_op),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    // gain table, multiply, accumulate and slice
    mbc_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_head            (w_head),
        .i_empty           (w_empty),
        .o_pop             (w_pop),
        .o_valid           (o_out_valid),
        .i_ready           (i_out_ready),
        .o_decoded_bit     (o_decoded_bit),
        .o_bit_error       (o_bit_error),
        .o_error_total     (o_error_total),
        .o_combined_metric (o_combined_metric)
    );

endmodule

`default_nettype wire

// File: sv/mbc_checker.sv
// port-level checks of the combiner, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module mbc_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               o_out_valid,
    input wire logic                               i_out_ready,
    input wire logic                               o_decoded_bit,
    input wire logic                               o_bit_error,
    input wire logic [mbc_pkg::COUNT_W-1:0]        o_error_total,
    input wire logic signed [mbc_pkg::ACC_W-1:0]   o_combined_metric
);

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // a stalled result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_combined_metric)
            && $stable(o_error_total))
        else $error("stalled result changed");

    // slice agrees with the metric sign
    a_slice: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_decoded_bit ==
            (!o_combined_metric[mbc_pkg::ACC_W-1] && (o_combined_metric != '0))))
        else $error("decoded bit disagrees with metric");

    // an error symbol leaves a nonzero count
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bit_error |-> (o_error_total != '0))
        else $error("error flagged with zero count");

endmodule

bind mrc_bpsk_combiner_slicer mbc_checker u_mbc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_decoded_bit     (o_decoded_bit),
    .o_bit_error       (o_bit_error),
    .o_error_total     (o_error_total),
    .o_combined_metric (o_combined_metric)
);

`default_nettype wire

// File: verif/tb_mrc_bpsk_combiner_slicer.sv
// self-checking testbench for the bpsk combiner and slicer with a cycle-free predictor
`timescale 1ns / 1ps

module tb_mrc_bpsk_combiner_slicer;

    // one input beat as it sits on the bus
    typedef struct packed {
        mbc_pkg::t_func                     func;
        logic [mbc_pkg::ANT_W-1:0]          antenna;
        logic signed [mbc_pkg::VALUE_W-1:0] value_re;
        logic signed [mbc_pkg::VALUE_W-1:0] value_im;
        logic                               sent_bit;
        logic                               last;
    } t_beat;

    // one sliced symbol as the block reports it
    typedef struct packed {
        logic                               decoded_bit;
        logic                               bit_error;
        logic [mbc_pkg::COUNT_W-1:0]        error_total;
        logic signed [mbc_pkg::ACC_W-1:0]   metric;
    } t_symbol;

    localparam longint ACC_HI = (longint'(1) <<< (mbc_pkg::ACC_W - 1)) - 1;
    localparam longint ACC_LO = -ACC_HI - 1;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   in_valid = 1'b0;
    t_beat  cur_beat = '0;
    logic   out_ready = 1'b0;

    wire                                o_in_ready;
    wire                                o_out_valid;
    wire                                o_decoded_bit;
    wire                                o_bit_error;
    wire [mbc_pkg::COUNT_W-1:0]         o_error_total;
    wire signed [mbc_pkg::ACC_W-1:0]    o_combined_metric;

    mrc_bpsk_combiner_slicer dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (o_in_ready),
        .i_func            (cur_beat.func),
        .i_antenna         (cur_beat.antenna),
        .i_value_re        (cur_beat.value_re),
        .i_value_im        (cur_beat.value_im),
        .i_sent_bit        (cur_beat.sent_bit),
        .i_last_antenna    (cur_beat.last),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (out_ready),
        .o_decoded_bit     (o_decoded_bit),
        .o_bit_error       (o_bit_error),
        .o_error_total     (o_error_total),
        .o_combined_metric (o_combined_metric)
    );

    // beats waiting to be driven, symbols waiting to come out
    t_beat   pending_beats[$];
    t_symbol expected_symbols[$];

    // combiner state as the predictor sees it
    logic signed [mbc_pkg::GAIN_W-1:0] gain_re [mbc_pkg::RX_ANTENNAS];
    logic signed [mbc_pkg::GAIN_W-1:0] gain_im [mbc_pkg::RX_ANTENNAS];
    logic signed [mbc_pkg::ACC_W-1:0]  acc_model = '0;
    logic [mbc_pkg::COUNT_W-1:0]       err_model = '0;

    int n_queued = 0;      // beats handed to the driver
    int n_offered = 0;     // beats put on the bus
    int n_accepted = 0;    // beats taken by the block
    int n_results = 0;     // symbols taken from the block
    int n_mismatch = 0;
    int n_bit_err = 0;
    int n_sat = 0;
    int n_wrap = 0;

    // sender burst shaping
    int burst_left = 8;
    int gap_left = 0;

    // receiver stall pattern and the one long hold-off
    int  ready_mode = 0;
    int  mode_left = 0;
    int  long_hold_left = 0;
    bit  long_hold_done = 1'b0;

    initial begin
        foreach (gain_re[i]) begin
            gain_re[i] = '0;
            gain_im[i] = '0;
        end
    end

    // clock and reset
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("timeout: %0d beats accepted, %0d symbols still expected",
                 n_accepted, expected_symbols.size());
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        n_mismatch++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // advance the combiner model by one accepted beat
    task automatic combine_beat(input t_beat b);
        longint  wide;
        longint  term;
        t_symbol sym;
        int      a;
        a = b.antenna;
        case (b.func)
            mbc_pkg::FUNC_CLEAR: begin
                foreach (gain_re[i]) begin
                    gain_re[i] = '0;
                    gain_im[i] = '0;
                end
                acc_model = '0;
            end
            mbc_pkg::FUNC_CLR_ERR: err_model = '0;
            mbc_pkg::FUNC_COEF: begin
                if (a < mbc_pkg::RX_ANTENNAS) begin
                    // gains wrap in two's complement
                    wide = longint'(gain_re[a]) + longint'(b.value_re);
                    gain_re[a] = wide[mbc_pkg::GAIN_W-1:0];
                    if (longint'(gain_re[a]) != wide)
                        n_wrap++;
                    wide = longint'(gain_im[a]) + longint'(b.value_im);
                    gain_im[a] = wide[mbc_pkg::GAIN_W-1:0];
                    if (longint'(gain_im[a]) != wide)
                        n_wrap++;
                end
            end
            default: begin
                // re(conj(g) * s), saturating into the accumulator
                if (a < mbc_pkg::RX_ANTENNAS) begin
                    term = longint'(gain_re[a]) * longint'(b.value_re)
                         + longint'(gain_im[a]) * longint'(b.value_im);
                    wide = longint'(acc_model) + term;
                    if (wide > ACC_HI) begin
                        wide = ACC_HI;
                        n_sat++;
                    end else if (wide < ACC_LO) begin
                        wide = ACC_LO;
                        n_sat++;
                    end
                    acc_model = wide[mbc_pkg::ACC_W-1:0];
                end
                if (b.last) begin
                    sym.decoded_bit = (acc_model > 0);
                    sym.bit_error   = sym.decoded_bit ^ b.sent_bit;
                    if (sym.bit_error) begin
                        n_bit_err++;
                        if (err_model != '1)
                            err_model = err_model + 1'b1;
                    end
                    sym.error_total = err_model;
                    sym.metric      = acc_model;
                    expected_symbols.push_back(sym);
                    acc_model = '0;
                end
            end
        endcase
    endtask

    // driver: next beat goes out at the falling edge once the last one was taken
    always @(negedge i_clk) begin
        t_beat nxt;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || n_accepted == n_offered) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end else if (pending_beats.size() == 0) begin
                in_valid <= 1'b0;
            end else begin
                nxt = pending_beats.pop_front();
                cur_beat  <= nxt;
                in_valid  <= 1'b1;
                n_offered <= n_offered + 1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // receiver: stall pattern picks a new random mode whenever the current one runs out
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (long_hold_left > 0) begin
            long_hold_left <= long_hold_left - 1;
            out_ready <= 1'b0;
        end else if (!long_hold_done && n_results >= 20) begin
            // long hold-off so the queue fills and the input stalls
            long_hold_done <= 1'b1;
            long_hold_left <= 120;
            out_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode <= $urandom_range(0, 2);
                mode_left  <= $urandom_range(5, 40);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (ready_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= $urandom_range(0, 1);
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // monitor: check taken symbols, then predict from the beat taken at this edge
    always @(posedge i_clk) begin
        t_symbol exp_sym;
        if (i_rst_n) begin
            if (o_out_valid && out_ready) begin
                n_results <= n_results + 1;
                if (expected_symbols.size() == 0) begin
                    report_mismatch($sformatf("symbol out with none expected, metric %0d",
                                              o_combined_metric));
                end else begin
                    exp_sym = expected_symbols.pop_front();
                    if (o_decoded_bit !== exp_sym.decoded_bit)
                        report_mismatch($sformatf("decoded_bit %b, expected %b",
                                                  o_decoded_bit, exp_sym.decoded_bit));
                    if (o_bit_error !== exp_sym.bit_error)
                        report_mismatch($sformatf("bit_error %b, expected %b",
                                                  o_bit_error, exp_sym.bit_error));
                    if (o_error_total !== exp_sym.error_total)
                        report_mismatch($sformatf("error_total %0d, expected %0d",
                                                  o_error_total, exp_sym.error_total));
                    if (o_combined_metric !== exp_sym.metric)
                        report_mismatch($sformatf("combined_metric %0d, expected %0d",
                                                  o_combined_metric, exp_sym.metric));
                end
            end
            if (in_valid && o_in_ready) begin
                combine_beat(cur_beat);
                n_accepted <= n_accepted + 1;
            end
        end
    end

    function automatic void queue_beat(mbc_pkg::t_func f, int ant, int re, int im,
                                       bit sent, bit last);
        t_beat b;
        b.func     = f;
        b.antenna  = ant[mbc_pkg::ANT_W-1:0];
        b.value_re = re[mbc_pkg::VALUE_W-1:0];
        b.value_im = im[mbc_pkg::VALUE_W-1:0];
        b.sent_bit = sent;
        b.last     = last;
        pending_beats.push_back(b);
        n_queued++;
    endfunction

    function automatic int rand_value();
        case ($urandom_range(0, 7))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3, 4: return int'($urandom_range(0, 8192)) - 4096;
            default: return int'($signed(16'($urandom)));
        endcase
    endfunction

    // one symbol worth of beats: mostly well formed, some heavy, some noise
    function automatic void queue_symbol();
        int kind;
        int n_ant;
        int n_coef;
        int n_samp;
        int ant;
        int ext;
        kind = $urandom_range(0, 15);
        if (kind == 0) begin
            // extreme gains pushed near or past wrap, then extreme samples into saturation
            ext = $urandom_range(0, 1) ? 32767 : -32768;
            ant = $urandom_range(0, mbc_pkg::RX_ANTENNAS - 1);
            queue_beat(mbc_pkg::FUNC_CLEAR, 0, 0, 0, 0, 0);
            n_coef = $urandom_range(8, 10);
            for (int i = 0; i < n_coef; i++)
                queue_beat(mbc_pkg::FUNC_COEF, ant, ext, ext, 0, 0);
            n_samp = $urandom_range(8, 12);
            ext = $urandom_range(0, 1) ? 32767 : -32768;
            for (int i = 0; i < n_samp; i++)
                queue_beat(mbc_pkg::FUNC_SAMPLE, ant, ext, ext, $urandom_range(0, 1),
                           i == n_samp - 1);
        end else if (kind <= 2) begin
            // noise: any field, any value
            n_samp = $urandom_range(1, 4);
            for (int i = 0; i < n_samp; i++)
                queue_beat(mbc_pkg::t_func'($urandom_range(0, 3)), $urandom_range(0, 7),
                           rand_value(), rand_value(), $urandom_range(0, 1),
                           $urandom_range(0, 1));
        end else begin
            if ($urandom_range(0, 2) == 0)
                queue_beat(mbc_pkg::FUNC_CLEAR, $urandom_range(0, 7), 0, 0, 0, 0);
            if ($urandom_range(0, 19) == 0)
                queue_beat(mbc_pkg::FUNC_CLR_ERR, 0, 0, 0, 0, 0);
            n_ant = $urandom_range(1, 4);
            for (int k = 0; k < n_ant; k++) begin
                ant = $urandom_range(0, 7);
                n_coef = $urandom_range(1, 3);
                for (int i = 0; i < n_coef; i++)
                    queue_beat(mbc_pkg::FUNC_COEF, ant, rand_value(), rand_value(), 0, 0);
            end
            n_samp = $urandom_range(1, 5);
            for (int i = 0; i < n_samp; i++)
                queue_beat(mbc_pkg::FUNC_SAMPLE, $urandom_range(0, 7), rand_value(),
                           rand_value(), $urandom_range(0, 1), i == n_samp - 1);
        end
    endfunction

    // block until every queued beat is taken and every symbol has come out
    task automatic wait_drained();
        while (n_accepted != n_queued || expected_symbols.size() != 0)
            @(negedge i_clk);
    endtask

    // stimulus sequencing and end of run
    initial begin
        int start;
        wait (i_rst_n === 1'b1);

        // directed: field extremes, every func, zero and negative metrics
        queue_beat(mbc_pkg::FUNC_CLR_ERR, 7, -32768, 32767, 1, 1);  // stray sent/last ignored
        queue_beat(mbc_pkg::FUNC_SAMPLE, 0, 0, 0, 0, 1);            // zero metric slices to 0
        queue_beat(mbc_pkg::FUNC_SAMPLE, 0, 32767, 32767, 1, 1);    // zero gain, counted error
        queue_beat(mbc_pkg::FUNC_COEF, 0, 32767, 32767, 1, 1);      // last ignored on coef
        queue_beat(mbc_pkg::FUNC_COEF, 7, -32768, -32768, 0, 0);
        queue_beat(mbc_pkg::FUNC_COEF, 7, -32768, -32768, 0, 0);
        queue_beat(mbc_pkg::FUNC_SAMPLE, 0, 32767, -32768, 0, 0);
        queue_beat(mbc_pkg::FUNC_SAMPLE, 7, -32768, 32767, 0, 0);
        queue_beat(mbc_pkg::FUNC_SAMPLE, 3, 12345, -1, 1, 1);       // antenna with no gain
        queue_beat(mbc_pkg::FUNC_SAMPLE, 0, 4096, 4096, 0, 1);      // positive, bit error
        queue_beat(mbc_pkg::FUNC_COEF, 2, 100, -200, 0, 0);
        queue_beat(mbc_pkg::FUNC_SAMPLE, 2, -5, 3, 0, 1);           // negative metric
        queue_beat(mbc_pkg::FUNC_CLEAR, 5, -1, -1, 1, 1);           // stray fields ignored
        queue_beat(mbc_pkg::FUNC_SAMPLE, 0, 32767, 32767, 1, 1);    // gains gone after clear
        queue_beat(mbc_pkg::FUNC_CLR_ERR, 0, 0, 0, 0, 0);
        queue_beat(mbc_pkg::FUNC_SAMPLE, 1, -1, -1, 0, 1);
        queue_beat(mbc_pkg::FUNC_COEF, 4, -1, 1, 0, 0);
        queue_beat(mbc_pkg::FUNC_SAMPLE, 4, -32768, 32767, 1, 1);
        wait_drained();

        // random in two halves, with a full drain between them
        start = n_queued;
        while (n_queued - start < 200)
            queue_symbol();
        wait_drained();
        start = n_queued;
        while (n_queued - start < 200)
            queue_symbol();
        wait_drained();

        repeat (10) @(negedge i_clk);
        if (expected_symbols.size() != 0)
            report_mismatch($sformatf("%0d symbols never came out", expected_symbols.size()));

        $display("covered %0d beats and %0d symbols, %0d bit errors predicted",
                 n_accepted, n_results, n_bit_err);
        $display("accumulator saturated %0d times, gain sums wrapped %0d times",
                 n_sat, n_wrap);
        if (n_mismatch == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", n_mismatch);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
